### rtl/core/qdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qdc_pkg
// Shared types and constants of the readout word parser: word type codes,
// parse status codes, parser state and per-word result records.
// ----------------------------------------------------------------------------
package qdc_pkg;

  // Default depth of a readout buffer in words
  localparam int MAX_WORDS_DEF = 4096;

  // Largest count a 12-bit gate index can follow
  localparam logic [12:0] GATE_CAP = 13'd4096;

  // Word type, bits 26..24 of a readout word
  localparam int          TYPE_LSB    = 24;
  localparam logic [2:0]  TYPE_DATA   = 3'd0;
  localparam logic [2:0]  TYPE_HEADER = 3'd2;
  localparam logic [2:0]  TYPE_EOB    = 3'd4;

  // Data word fields
  localparam int CHAN_LSB  = 16;
  localparam int FLAG_LSB  = 12;

  typedef enum logic [2:0] {
    ST_RUN     = 3'd0,
    ST_DONE    = 3'd1,
    ST_STRAY   = 3'd2,
    ST_NESTED  = 3'd3,
    ST_BADTYPE = 3'd4
  } status_e;

  typedef struct packed {
    logic        in_block;
    logic [12:0] headers_seen;
    logic [12:0] hits_so_far;
    logic        parse_stopped;
  } parse_state_t;

  typedef struct packed {
    logic        hit_valid;
    logic [4:0]  channel;
    logic [11:0] adc_value;
    logic [11:0] gate_index;
    status_e     parse_status;
    logic [12:0] hit_count;
  } parse_result_t;

endpackage

### rtl/core/qdc_word_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qdc_word_decode
// Decodes one readout word against the current parser state and yields the
// next state and the result record of that word.
// ----------------------------------------------------------------------------
module qdc_word_decode #(
  parameter int MaxWords = qdc_pkg::MAX_WORDS_DEF
) (
  input  logic [31:0]           data_word_i,
  input  logic                  first_word_i,
  input  logic                  last_word_i,
  input  qdc_pkg::parse_state_t state_i,
  output qdc_pkg::parse_state_t state_o,
  output qdc_pkg::parse_result_t result_o
);
  import qdc_pkg::*;

  localparam int          HitCapInt = (MaxWords < 4096) ? MaxWords : 4096;
  localparam logic [12:0] HitCap    = 13'(HitCapInt);

  parse_state_t cur;
  parse_state_t nxt;
  status_e      status;
  logic [2:0]   wtype;
  logic [12:0]  gate_m1;

  assign wtype   = data_word_i[TYPE_LSB +: 3];
  assign gate_m1 = cur.headers_seen - 13'd1;

  always_comb begin
    // first word of a buffer starts from a clean state
    cur = first_word_i ? '0 : state_i;
    nxt = cur;
    status = ST_RUN;
    result_o = '0;

    if (cur.parse_stopped) begin
      status = ST_DONE;
    end else if (&data_word_i) begin
      status = ST_DONE;
    end else if (!cur.in_block) begin
      if (wtype == TYPE_HEADER) begin
        nxt.in_block = 1'b1;
        if (cur.headers_seen < GATE_CAP) begin
          nxt.headers_seen = cur.headers_seen + 13'd1;
        end
      end else begin
        status = ST_STRAY;
      end
    end else if (wtype == TYPE_HEADER) begin
      status = ST_NESTED;
    end else if (wtype == TYPE_EOB) begin
      nxt.in_block = 1'b0;
    end else if (wtype == TYPE_DATA) begin
      // drop overflow and under-threshold words
      if (data_word_i[FLAG_LSB +: 2] == 2'b00) begin
        result_o.hit_valid = 1'b1;
        result_o.channel   = data_word_i[CHAN_LSB +: 5];
        result_o.adc_value = data_word_i[11:0];
        if (cur.headers_seen == 13'd0) begin
          result_o.gate_index = 12'd0;
        end else if (gate_m1[12]) begin
          result_o.gate_index = 12'hFFF;
        end else begin
          result_o.gate_index = gate_m1[11:0];
        end
        if (cur.hits_so_far < HitCap) begin
          nxt.hits_so_far = cur.hits_so_far + 13'd1;
        end
      end
    end else begin
      status = ST_BADTYPE;
    end

    if (status == ST_RUN && last_word_i) begin
      status = ST_DONE;
    end
    if (status != ST_RUN) begin
      nxt.parse_stopped = 1'b1;
    end

    result_o.parse_status = status;
    result_o.hit_count    = nxt.hits_so_far;
    state_o = nxt;
  end

endmodule

### rtl/core/qdc_event_word_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qdc_event_word_parser
// Parses readout words of a charge converter buffer into hits, one word per
// request, and reports parse status and running hit count with every word.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake                | Payload
//  --------+-----------+--------------------------+-----------------------------
//  in      | input     | in_valid_i / in_stall_o  | data_word_i, first_word_i,
//          |           |                          | last_word_i
//  out     | output    | out_valid_o / out_stall_i| hit_valid_o, channel_o,
//          |           |                          | adc_value_o, gate_index_o,
//          |           |                          | parse_status_o, hit_count_o
//
//  One request is taken per cycle while in_stall_o is low; each gives exactly
//  one result, presented on the output once it has passed the input register
//  and been decoded into the result register, where it waits to be taken.
//  The parser state loop (block flag, gate and hit counters) closes through
//  the decoder, which sets the one-per-cycle rate.
//  Reset (rst_ni low, asynchronous) empties both stages and clears the state.
//  A stall on the output holds the result register, then the input register,
//  then raises in_stall_o; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module qdc_event_word_parser #(
  parameter int MAX_WORDS = qdc_pkg::MAX_WORDS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] data_word_i,
  input  logic        first_word_i,
  input  logic        last_word_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        hit_valid_o,
  output logic [4:0]  channel_o,
  output logic [11:0] adc_value_o,
  output logic [11:0] gate_index_o,
  output logic [2:0]  parse_status_o,
  output logic [12:0] hit_count_o
);
  import qdc_pkg::*;

  localparam int          HitCapInt = (MAX_WORDS < 4096) ? MAX_WORDS : 4096;
  localparam logic [12:0] HitCap    = 13'(HitCapInt);

  // input register
  logic        in_valid_q;
  logic [31:0] word_q;
  logic        first_q;
  logic        last_q;

  // result register
  logic          out_valid_q;
  parse_result_t result_q;
  parse_result_t result_d;

  // parser state
  parse_state_t  state_q;
  parse_state_t  state_d;

  logic out_adv;   // result register may load
  logic dec_fire;  // word in input register moves to result register
  logic in_adv;    // input register may load

  assign out_adv  = !out_valid_q || !out_stall_i;
  assign dec_fire = in_valid_q && out_adv;
  assign in_adv   = !in_valid_q || out_adv;
  assign in_stall_o = !in_adv;

  qdc_word_decode #(
    .MaxWords(MAX_WORDS)
  ) u_decode (
    .data_word_i (word_q),
    .first_word_i(first_q),
    .last_word_i (last_q),
    .state_i     (state_q),
    .state_o     (state_d),
    .result_o    (result_d)
  );

  // input stage: load a new request whenever the stage drains
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_adv) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && in_valid_i) begin
      word_q  <= data_word_i;
      first_q <= first_word_i;
      last_q  <= last_word_i;
    end
  end

  // result stage and state: advance only when the decoded word is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (out_adv) begin
        out_valid_q <= in_valid_q;
      end
      if (dec_fire) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (dec_fire) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hit_valid_o    = result_q.hit_valid;
  assign channel_o      = result_q.channel;
  assign adc_value_o    = result_q.adc_value;
  assign gate_index_o   = result_q.gate_index;
  assign parse_status_o = result_q.parse_status;
  assign hit_count_o    = result_q.hit_count;

  // hit counter saturates at its cap
  a_hit_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.hits_so_far <= HitCap)
    else $error("hit counter beyond cap");

  // header counter saturates at the gate cap
  a_gate_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.headers_seen <= GATE_CAP)
    else $error("header counter beyond cap");

  // an open block always has a header behind it
  a_block_header : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.in_block |-> (state_q.headers_seen != 13'd0))
    else $error("open block without header");

  // a delivered hit only comes with a running or finished parse
  a_hit_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && result_q.hit_valid) |->
      (result_q.parse_status == ST_RUN || result_q.parse_status == ST_DONE))
    else $error("hit reported with error status");

endmodule
